[sv/gs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gs_pkg
// Shared types, codes and fixed-point helpers of the Gauss-Seidel solver.
// ----------------------------------------------------------------------------
package gs_pkg;

  localparam int WORD_W  = 48;
  localparam int FRAC_W  = 24;
  localparam int HALF_W  = WORD_W / 2;
  localparam int PROD_W  = 2 * WORD_W;
  localparam int QUO_W   = WORD_W + FRAC_W;
  localparam int DCNT_W  = $clog2(QUO_W);
  localparam int KIND_W  = 2;
  localparam int CIDX_W  = 2;
  localparam int DIM_W   = 9;
  localparam int ITER_W  = 16;
  localparam int TOL_W   = 25;
  localparam int CFG_W   = 25;

  localparam logic signed [WORD_W-1:0] WMAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam logic signed [WORD_W-1:0] WMIN = {1'b1, {(WORD_W-1){1'b0}}};

  // partial product selects: coefficient half, then solution half
  localparam logic [1:0] MUL_LL = 2'd0;
  localparam logic [1:0] MUL_LH = 2'd1;
  localparam logic [1:0] MUL_HL = 2'd2;
  localparam logic [1:0] MUL_HH = 2'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_COEF  = 2'd0,
    KIND_RHS   = 2'd1,
    KIND_SOLVE = 2'd2,
    KIND_READ  = 2'd3
  } kind_t;

  typedef enum logic [CIDX_W-1:0] {
    CFG_DIM  = 2'd0,
    CFG_ITER = 2'd1,
    CFG_TOL  = 2'd2
  } cfg_idx_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_READ_WAIT, ST_CLEAR, ST_SWEEP_CHK, ST_ROW_FETCH, ST_ROW_LOAD,
    ST_J_FETCH, ST_J_EXEC, ST_MUL1, ST_MUL2, ST_MUL3, ST_ACC, ST_DIV_INIT,
    ST_DIV_STEP, ST_DIV_FIN, ST_ROW_DONE, ST_SWEEP_END, ST_DONE
  } state_t;

  typedef struct packed {
    logic       rd_host;
    logic       load_coef;
    logic       load_rhs;
    logic       accept_read;
    logic       start;
    logic       clr_step;
    logic       sweep_start;
    logic       sum_load;
    logic       j_capture;
    logic       j_next;
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       acc_sub;
    logic       div_init;
    logic       div_step;
    logic       div_fin;
    logic       row_done;
    logic       i_next;
    logic       k_inc;
    logic       out_load;
    logic       out_sel;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic k_at_max;
    logic j_is_diag;
    logic j_last;
    logic i_last;
    logic diag_zero;
    logic div_last;
    logic converged;
  } sts_t;

  function automatic logic signed [WORD_W-1:0] sat_sub(
      input logic signed [WORD_W-1:0] a,
      input logic signed [WORD_W-1:0] b);
    logic signed [WORD_W:0] d;
    d = {a[WORD_W-1], a} - {b[WORD_W-1], b};
    if (d[WORD_W] != d[WORD_W-1]) sat_sub = d[WORD_W] ? WMIN : WMAX;
    else sat_sub = d[WORD_W-1:0];
  endfunction

  // arithmetic shift by the fraction width, then clamp to the word
  function automatic logic signed [WORD_W-1:0] sat_prod(
      input logic signed [PROD_W-1:0] p);
    logic [PROD_W-FRAC_W-WORD_W:0] top;
    top = p[PROD_W-1:FRAC_W+WORD_W-1];
    if ((&top) || !(|top)) sat_prod = p[FRAC_W+WORD_W-1:FRAC_W];
    else sat_prod = p[PROD_W-1] ? WMIN : WMAX;
  endfunction

endpackage

[sv/gauss_seidel_linear_solver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gauss_seidel_linear_solver
// Gauss-Seidel solver for A x = b, signed Q24.24 in 48-bit words.
// ----------------------------------------------------------------------------
// Requests arrive on in_valid/in_stall with in_kind, in_row, in_col, in_value.
// Coefficient and rhs loads produce no result; they are taken back to back
// while the block is idle. A read returns x[row] on the out_ channel through
// the registered read of the x store and then the result register.
// A solve first clears all MAX_DIM entries of x, then runs sweeps. Each row
// of a sweep forms its off-diagonal products with the split 48x48 multiply,
// one quarter product at a time, and then runs the 72-step restoring divider
// unless the diagonal is zero. The finish result follows the last sweep.
// Solve and read requests stall while an earlier result still waits; loads do
// not. The result register holds until out_stall drops.
// Reset (rst_n low, synchronous) returns the FSM to idle, empties the result
// register, sets dimension 256, max_iterations 500, tolerance 17 and makes
// reads return zero until a solve has run. Config writes go to cfg_index
// 0 dimension, 1 max_iterations, 2 tolerance; they are to be made only while
// the block is idle, which is up to the user: the block itself does not enforce it.
// ----------------------------------------------------------------------------
module gauss_seidel_linear_solver #(
  parameter int MAX_DIM = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gs_pkg::CIDX_W-1:0]           cfg_index,
  input  logic [gs_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [gs_pkg::KIND_W-1:0]           in_kind,
  input  logic [7:0]                          in_row,
  input  logic [7:0]                          in_col,
  input  logic signed [gs_pkg::WORD_W-1:0]    in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_result_kind,
  output logic signed [gs_pkg::WORD_W-1:0]    out_element_value,
  output logic [gs_pkg::ITER_W-1:0]           out_iteration_count,
  output logic                                out_divide_fault
);

  gs_pkg::cmd_t cmd;
  gs_pkg::sts_t sts;

  gs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gs_dp #(.MAX_DIM(MAX_DIM)) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_row              (in_row),
    .in_col              (in_col),
    .in_value            (in_value),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_result_kind     (out_result_kind),
    .out_element_value   (out_element_value),
    .out_iteration_count (out_iteration_count),
    .out_divide_fault    (out_divide_fault)
  );

endmodule

[sv/gs_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gs_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gs_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/gs_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gs_ctrl
// Sequencer of the solver: request handshake, sweeps, rows, products, divide.
// ----------------------------------------------------------------------------
module gs_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [gs_pkg::KIND_W-1:0] in_kind,
  output logic                      in_stall,
  output logic                      out_valid,
  input  logic                      out_stall,
  input  gs_pkg::sts_t              sts,
  output gs_pkg::cmd_t              cmd
);

  gs_pkg::state_t state_r, state_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic           gives_result;
  logic           in_acc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // loads never wait on the result register
  assign gives_result = (in_kind == gs_pkg::KIND_SOLVE) || (in_kind == gs_pkg::KIND_READ);
  assign in_stall     = (state_r != gs_pkg::ST_IDLE) || (gives_result && out_valid_r);
  assign in_acc       = in_valid && !in_stall;
  assign out_valid    = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      gs_pkg::ST_IDLE: begin
        cmd.rd_host = 1'b1;
        if (in_acc) begin
          unique case (gs_pkg::kind_t'(in_kind))
            gs_pkg::KIND_COEF: cmd.load_coef = 1'b1;
            gs_pkg::KIND_RHS:  cmd.load_rhs  = 1'b1;
            gs_pkg::KIND_SOLVE: begin
              cmd.start = 1'b1;
              state_nxt = gs_pkg::ST_CLEAR;
            end
            gs_pkg::KIND_READ: begin
              cmd.accept_read = 1'b1;
              state_nxt       = gs_pkg::ST_READ_WAIT;
            end
            default: ;
          endcase
        end
      end
      gs_pkg::ST_READ_WAIT: begin
        cmd.out_load = 1'b1;
        cmd.out_sel  = 1'b1;
        state_nxt    = gs_pkg::ST_IDLE;
      end
      gs_pkg::ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = gs_pkg::ST_SWEEP_CHK;
      end
      gs_pkg::ST_SWEEP_CHK: begin
        if (sts.k_at_max) begin
          state_nxt = gs_pkg::ST_DONE;
        end else begin
          cmd.sweep_start = 1'b1;
          state_nxt       = gs_pkg::ST_ROW_FETCH;
        end
      end
      gs_pkg::ST_ROW_FETCH: state_nxt = gs_pkg::ST_ROW_LOAD;
      gs_pkg::ST_ROW_LOAD: begin
        cmd.sum_load = 1'b1;
        state_nxt    = gs_pkg::ST_J_EXEC;
      end
      gs_pkg::ST_J_FETCH: state_nxt = gs_pkg::ST_J_EXEC;
      gs_pkg::ST_J_EXEC: begin
        if (sts.j_is_diag) begin
          cmd.j_capture = 1'b1;
          if (sts.j_last) begin
            state_nxt = gs_pkg::ST_DIV_INIT;
          end else begin
            cmd.j_next = 1'b1;
            state_nxt  = gs_pkg::ST_J_FETCH;
          end
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = gs_pkg::MUL_LL;
          state_nxt   = gs_pkg::ST_MUL1;
        end
      end
      gs_pkg::ST_MUL1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = gs_pkg::MUL_LH;
        state_nxt   = gs_pkg::ST_MUL2;
      end
      gs_pkg::ST_MUL2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = gs_pkg::MUL_HL;
        state_nxt   = gs_pkg::ST_MUL3;
      end
      gs_pkg::ST_MUL3: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = gs_pkg::MUL_HH;
        state_nxt   = gs_pkg::ST_ACC;
      end
      gs_pkg::ST_ACC: begin
        cmd.acc_sub = 1'b1;
        if (sts.j_last) begin
          state_nxt = gs_pkg::ST_DIV_INIT;
        end else begin
          cmd.j_next = 1'b1;
          state_nxt  = gs_pkg::ST_J_FETCH;
        end
      end
      gs_pkg::ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = sts.diag_zero ? gs_pkg::ST_ROW_DONE : gs_pkg::ST_DIV_STEP;
      end
      gs_pkg::ST_DIV_STEP: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = gs_pkg::ST_DIV_FIN;
      end
      gs_pkg::ST_DIV_FIN: begin
        cmd.div_fin = 1'b1;
        state_nxt   = gs_pkg::ST_ROW_DONE;
      end
      gs_pkg::ST_ROW_DONE: begin
        cmd.row_done = 1'b1;
        if (sts.i_last) begin
          state_nxt = gs_pkg::ST_SWEEP_END;
        end else begin
          cmd.i_next = 1'b1;
          state_nxt  = gs_pkg::ST_ROW_FETCH;
        end
      end
      gs_pkg::ST_SWEEP_END: begin
        if (sts.converged) begin
          state_nxt = gs_pkg::ST_DONE;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = gs_pkg::ST_SWEEP_CHK;
        end
      end
      gs_pkg::ST_DONE: begin
        cmd.out_load = 1'b1;
        state_nxt    = gs_pkg::ST_IDLE;
      end
      default: state_nxt = gs_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> state_r == gs_pkg::ST_IDLE)
    else $error("request accepted outside idle");

  a_load_empty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid_r)
    else $error("result register overwritten");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gs_pkg::ST_IDLE |-> !cmd.clr_step && !cmd.row_done)
    else $error("solution write while idle");

  a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gs_pkg::ST_SWEEP_END && sts.converged |=> state_r == gs_pkg::ST_DONE)
    else $error("converged sweep did not finish");

endmodule

[sv/gs_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gs_dp
// Solver datapath: stores, config registers, split multiplier, divider.
// ----------------------------------------------------------------------------
module gs_dp #(
  parameter int MAX_DIM = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gs_pkg::CIDX_W-1:0]           cfg_index,
  input  logic [gs_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic [7:0]                          in_row,
  input  logic [7:0]                          in_col,
  input  logic signed [gs_pkg::WORD_W-1:0]    in_value,
  input  gs_pkg::cmd_t                        cmd,
  output gs_pkg::sts_t                        sts,
  output logic                                out_result_kind,
  output logic signed [gs_pkg::WORD_W-1:0]    out_element_value,
  output logic [gs_pkg::ITER_W-1:0]           out_iteration_count,
  output logic                                out_divide_fault
);

  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int W     = gs_pkg::WORD_W;
  localparam int H     = gs_pkg::HALF_W;
  localparam int QW    = gs_pkg::QUO_W;

  // configuration
  logic [gs_pkg::DIM_W-1:0]  dim_r;
  logic [gs_pkg::ITER_W-1:0] iter_r;
  logic [gs_pkg::TOL_W-1:0]  tol_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r  <= gs_pkg::DIM_W'(256);
      iter_r <= gs_pkg::ITER_W'(500);
      tol_r  <= gs_pkg::TOL_W'(17);
    end else if (cfg_we) begin
      unique case (gs_pkg::cfg_idx_t'(cfg_index))
        gs_pkg::CFG_DIM:  dim_r  <= cfg_wdata[gs_pkg::DIM_W-1:0];
        gs_pkg::CFG_ITER: iter_r <= cfg_wdata[gs_pkg::ITER_W-1:0];
        gs_pkg::CFG_TOL:  tol_r  <= cfg_wdata[gs_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [IDX_W-1:0] n_m1;
  always_comb begin
    if (dim_r == '0) n_m1 = '0;
    else if (32'(dim_r) > 32'(MAX_DIM)) n_m1 = IDX_W'(MAX_DIM - 1);
    else n_m1 = IDX_W'(dim_r - gs_pkg::DIM_W'(1));
  end

  // host-side index decode
  logic             row_ok, col_ok;
  logic [IDX_W-1:0] row_idx, col_idx;
  assign row_ok  = 32'(in_row) < 32'(MAX_DIM);
  assign col_ok  = 32'(in_col) < 32'(MAX_DIM);
  assign row_idx = IDX_W'(in_row);
  assign col_idx = IDX_W'(in_col);

  // control-side registers
  logic [IDX_W-1:0]          i_r, j_r, clr_r;
  logic [gs_pkg::ITER_W-1:0] k_r;
  logic                      fault_r, solved_r;
  logic [W-1:0]              largest_r;

  // payload registers
  logic signed [W-1:0]                sum_r, diag_r, xold_r, xnew_r;
  logic signed [gs_pkg::PROD_W-1:0]   acc_r;
  logic [QW-1:0]                      num_r, q_r;
  logic [W-1:0]                       rem_r, md_r;
  logic                               neg_r, rd_ok_r;
  logic [gs_pkg::DCNT_W-1:0]          dcnt_r;

  // stores
  logic [W-1:0] coef_rdata, rhs_rdata, x_rdata, x_wdata;
  logic         x_we;
  logic [IDX_W-1:0] x_waddr, x_raddr;

  // rows sit on a power-of-two stride, so the store covers the full address space
  gs_ram #(.WIDTH(W), .DEPTH(1 << (2 * IDX_W))) u_coef (
    .clk   (clk),
    .we    (cmd.load_coef && row_ok && col_ok),
    .waddr ({row_idx, col_idx}),
    .wdata (in_value),
    .raddr ({i_r, j_r}),
    .rdata (coef_rdata)
  );

  gs_ram #(.WIDTH(W), .DEPTH(MAX_DIM)) u_rhs (
    .clk   (clk),
    .we    (cmd.load_rhs && row_ok),
    .waddr (row_idx),
    .wdata (in_value),
    .raddr (i_r),
    .rdata (rhs_rdata)
  );

  assign x_we    = cmd.clr_step || cmd.row_done;
  assign x_waddr = cmd.clr_step ? clr_r : i_r;
  assign x_wdata = cmd.clr_step ? '0 : xnew_r;
  assign x_raddr = cmd.rd_host ? row_idx : j_r;

  gs_ram #(.WIDTH(W), .DEPTH(MAX_DIM)) u_x (
    .clk   (clk),
    .we    (x_we),
    .waddr (x_waddr),
    .wdata (x_wdata),
    .raddr (x_raddr),
    .rdata (x_rdata)
  );

  // one quarter of the 48x48 product per cycle
  logic signed [H:0]                  pa, pb;
  logic signed [2*H+1:0]              pp;
  logic signed [gs_pkg::PROD_W-1:0]   ppx;
  always_comb begin
    pa  = cmd.mul_sel[1] ? {coef_rdata[W-1], coef_rdata[W-1:H]} : {1'b0, coef_rdata[H-1:0]};
    pb  = cmd.mul_sel[0] ? {x_rdata[W-1], x_rdata[W-1:H]} : {1'b0, x_rdata[H-1:0]};
    pp  = pa * pb;
    ppx = gs_pkg::PROD_W'(pp);
    case (cmd.mul_sel)
      gs_pkg::MUL_LL: ppx = ppx;
      gs_pkg::MUL_HH: ppx = ppx <<< (2 * H);
      default:        ppx = ppx <<< H;
    endcase
  end

  // restoring divide step
  logic [W:0]   rem2;
  logic         qbit;
  logic [W:0]   rem_sub;
  always_comb begin
    rem2    = {rem_r, num_r[QW-1]};
    rem_sub = rem2 - {1'b0, md_r};
    qbit    = !rem_sub[W];
  end

  logic [W-1:0]        mag_sum, mag_diag;
  logic [QW-1:0]       limit;
  logic signed [W-1:0] delta, adelta;
  assign mag_sum  = sum_r[W-1] ? -sum_r : sum_r;
  assign mag_diag = diag_r[W-1] ? -diag_r : diag_r;
  assign limit    = QW'(gs_pkg::WMAX) + QW'(neg_r);
  always_comb begin
    delta  = gs_pkg::sat_sub(xnew_r, xold_r);
    if (!delta[W-1]) adelta = delta;
    else if (delta == gs_pkg::WMIN) adelta = gs_pkg::WMAX;
    else adelta = -delta;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r       <= '0;
      j_r       <= '0;
      clr_r     <= '0;
      k_r       <= '0;
      fault_r   <= 1'b0;
      solved_r  <= 1'b0;
      largest_r <= '0;
      dcnt_r    <= '0;
    end else begin
      if (cmd.start) begin
        k_r       <= '0;
        fault_r   <= 1'b0;
        solved_r  <= 1'b1;
        largest_r <= '0;
        clr_r     <= '0;
      end
      if (cmd.clr_step) clr_r <= clr_r + IDX_W'(1);
      if (cmd.sweep_start) begin
        i_r       <= '0;
        j_r       <= '0;
        largest_r <= '0;
      end
      if (cmd.j_next) j_r <= j_r + IDX_W'(1);
      if (cmd.i_next) begin
        i_r <= i_r + IDX_W'(1);
        j_r <= '0;
      end
      if (cmd.k_inc) k_r <= k_r + gs_pkg::ITER_W'(1);
      if (cmd.div_init) begin
        dcnt_r <= '0;
        if (diag_r == '0) fault_r <= 1'b1;
      end
      if (cmd.div_step) dcnt_r <= dcnt_r + gs_pkg::DCNT_W'(1);
      if (cmd.row_done && (adelta > largest_r)) largest_r <= adelta;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_load) sum_r <= rhs_rdata;
    if (cmd.j_capture) begin
      diag_r <= coef_rdata;
      xold_r <= x_rdata;
    end
    if (cmd.mul_en) acc_r <= (cmd.mul_sel == gs_pkg::MUL_LL) ? ppx : acc_r + ppx;
    if (cmd.acc_sub) sum_r <= gs_pkg::sat_sub(sum_r, gs_pkg::sat_prod(acc_r));
    if (cmd.accept_read) rd_ok_r <= row_ok && solved_r;
    if (cmd.div_init) begin
      num_r  <= {mag_sum, {gs_pkg::FRAC_W{1'b0}}};
      md_r   <= mag_diag;
      rem_r  <= '0;
      q_r    <= '0;
      neg_r  <= sum_r[W-1] ^ diag_r[W-1];
      xnew_r <= sum_r[W-1] ? gs_pkg::WMIN : gs_pkg::WMAX;
    end
    if (cmd.div_step) begin
      num_r <= {num_r[QW-2:0], 1'b0};
      q_r   <= {q_r[QW-2:0], qbit};
      rem_r <= qbit ? rem_sub[W-1:0] : rem2[W-1:0];
    end
    if (cmd.div_fin) begin
      if (q_r > limit) xnew_r <= neg_r ? gs_pkg::WMIN : gs_pkg::WMAX;
      else xnew_r <= neg_r ? -q_r[W-1:0] : q_r[W-1:0];
    end
    if (cmd.out_load) begin
      out_result_kind     <= cmd.out_sel;
      out_element_value   <= (cmd.out_sel && rd_ok_r) ? x_rdata : '0;
      out_iteration_count <= cmd.out_sel ? '0 : k_r;
      out_divide_fault    <= cmd.out_sel ? 1'b0 : fault_r;
    end
  end

  assign sts.clr_last  = clr_r == IDX_W'(MAX_DIM - 1);
  assign sts.k_at_max  = k_r == iter_r;
  assign sts.j_is_diag = j_r == i_r;
  assign sts.j_last    = j_r == n_m1;
  assign sts.i_last    = i_r == n_m1;
  assign sts.diag_zero = diag_r == '0;
  assign sts.div_last  = dcnt_r == gs_pkg::DCNT_W'(QW - 1);
  assign sts.converged = largest_r < W'(tol_r);

endmodule
